@@ rtl/core/dq_pkg.sv @@
// Shared definitions for the double-ended queue core.
// No dependencies; imported by the top level.
`default_nettype none

package dq_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned OPCODE_W      = 3;
  localparam int unsigned DEPTH_DEFAULT = 1024;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_FRONT      = 3'd2,
    OP_BACK       = 3'd3,
    OP_SIZE       = 3'd4,
    OP_EMPTY      = 3'd5,
    OP_POP_FRONT  = 3'd6,
    OP_POP_BACK   = 3'd7
  } opcode_t;

endpackage

`default_nettype wire

@@ rtl/core/dq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/double_ended_queue_core.sv @@
// Double-ended queue of signed 32-bit words in a ring buffer held in dq_ram.
// Depends on dq_pkg and dq_ram.
//
// One command is taken per clock; busy is never raised, as every command
// needs at most one RAM access, done in the cycle it is accepted. Pushes
// give no result. Every other command gives one result, shown with done
// high for exactly one cycle, the cycle after the command was accepted
// (the RAM read is registered). The receiver cannot stall, so results
// must be taken when done is high. A push to a full queue is dropped;
// front/back/pop on an empty queue return -1 with was_empty set.
`default_nettype none

module double_ended_queue_core #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [dq_pkg::OPCODE_W-1:0]   opcode,
  input  wire logic signed [dq_pkg::WORD_W-1:0] push_value,
  output logic                               done,
  output logic signed [dq_pkg::WORD_W-1:0]   result_value,
  output logic                               was_empty
);

  import dq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW:0] DEPTH_S = (CW+1)'(DEPTH);

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;

  logic              accept;
  logic              full, empty;
  logic [AW-1:0]     head_dec, head_inc, tail_pos, back_pos;
  logic [CW:0]       tail_sum, back_sum;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              res_valid_next, res_mem_next, res_flag_next;
  logic [WORD_W-1:0] res_next;
  logic              res_mem;
  logic [WORD_W-1:0] res;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);

  // ring positions, wrapping modulo DEPTH
  assign tail_sum = (CW+1)'(head) + (CW+1)'(count);
  assign back_sum = (CW+1)'(head) + (CW+1)'(count) - (CW+1)'(1);
  assign tail_pos = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign back_pos = (back_sum >= DEPTH_S) ? AW'(back_sum - DEPTH_S) : AW'(back_sum);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  always_comb begin
    head_next      = head;
    count_next     = count;
    ram_we         = 1'b0;
    ram_waddr      = tail_pos;
    ram_re         = 1'b0;
    ram_raddr      = head;
    res_valid_next = 1'b0;
    res_mem_next   = 1'b0;
    res_flag_next  = 1'b0;
    res_next       = '1;
    if (accept) begin
      case (opcode)
        OP_PUSH_BACK: begin
          if (!full) begin
            ram_we     = 1'b1;
            count_next = count + CW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (!full) begin
            ram_we     = 1'b1;
            ram_waddr  = head_dec;
            head_next  = head_dec;
            count_next = count + CW'(1);
          end
        end
        OP_FRONT, OP_POP_FRONT: begin
          res_valid_next = 1'b1;
          if (empty) begin
            res_flag_next = 1'b1;
          end else begin
            ram_re       = 1'b1;
            res_mem_next = 1'b1;
            if (opcode == OP_POP_FRONT) begin
              head_next  = head_inc;
              count_next = count - CW'(1);
            end
          end
        end
        OP_BACK, OP_POP_BACK: begin
          res_valid_next = 1'b1;
          ram_raddr      = back_pos;
          if (empty) begin
            res_flag_next = 1'b1;
          end else begin
            ram_re       = 1'b1;
            res_mem_next = 1'b1;
            if (opcode == OP_POP_BACK) begin
              count_next = count - CW'(1);
            end
          end
        end
        OP_SIZE: begin
          res_valid_next = 1'b1;
          res_next       = WORD_W'(count);
        end
        default: begin
          res_valid_next = 1'b1;
          res_next       = WORD_W'(empty);
        end
      endcase
    end
  end

  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      done      <= 1'b0;
      res_mem   <= 1'b0;
      was_empty <= 1'b0;
    end else begin
      head      <= head_next;
      count     <= count_next;
      done      <= res_valid_next;
      res_mem   <= res_mem_next;
      was_empty <= res_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  // element words come straight from the RAM read register
  assign result_value = res_mem ? ram_rdata : res;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= AW'(DEPTH - 1))
    else $error("head index out of range");

  a_mem_not_empty: assert property (@(posedge clk) disable iff (rst)
    res_mem |-> (done && !was_empty))
    else $error("RAM word shown for an empty or absent result");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_POP_FRONT || opcode == OP_POP_BACK) && !empty)
      |=> (count == $past(count) - CW'(1)))
    else $error("pop did not remove one word");

  a_push_full_dropped: assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_PUSH_BACK || opcode == OP_PUSH_FRONT) && full)
      |=> ($stable(count) && $stable(head)))
    else $error("push to full queue changed state");

endmodule

`default_nettype wire

@@ dv/double_ended_queue_core_tb.sv @@
// Self-checking testbench for double_ended_queue_core: directed and random commands,
// with a local deque predictor that checks each result word as it is strobed.
// Depends on dq_pkg and the double_ended_queue_core RTL.
`default_nettype none

module double_ended_queue_core_tb;
  import dq_pkg::*;

  localparam int unsigned DQ_DEPTH = DEPTH_DEFAULT;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              empty_flag;
  } dq_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  opcode_t                   opcode = OP_PUSH_BACK;
  logic signed [WORD_W-1:0]  push_value = '0;
  logic                      done;
  logic signed [WORD_W-1:0]  result_value;
  logic                      was_empty;

  // predictor copy of the queue
  logic [WORD_W-1:0] model_store [DQ_DEPTH];
  int unsigned       model_head = 0;
  int unsigned       model_count = 0;

  dq_result_t pending_results [$];
  int         error_count = 0;
  bit         gaps_enabled = 1'b1;

  always #4 clk = ~clk;

  double_ended_queue_core #(.DEPTH(DQ_DEPTH)) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .push_value   (push_value),
    .done         (done),
    .result_value (result_value),
    .was_empty    (was_empty)
  );

  // Returns 1 when the command yields a result word.
  function automatic bit predict_deque(input opcode_t op, input logic [WORD_W-1:0] val,
                                       output dq_result_t res);
    int unsigned pos;
    res = '0;
    case (op)
      OP_PUSH_BACK: begin
        if (model_count < DQ_DEPTH) begin
          model_store[(model_head + model_count) % DQ_DEPTH] = val;
          model_count++;
        end
        return 1'b0;
      end
      OP_PUSH_FRONT: begin
        if (model_count < DQ_DEPTH) begin
          model_head = (model_head == 0) ? DQ_DEPTH - 1 : model_head - 1;
          model_store[model_head] = val;
          model_count++;
        end
        return 1'b0;
      end
      OP_FRONT, OP_POP_FRONT: begin
        if (model_count == 0) begin
          res.value = '1;
          res.empty_flag = 1'b1;
        end else begin
          res.value = model_store[model_head];
          if (op == OP_POP_FRONT) begin
            model_head = (model_head + 1) % DQ_DEPTH;
            model_count--;
          end
        end
      end
      OP_BACK, OP_POP_BACK: begin
        if (model_count == 0) begin
          res.value = '1;
          res.empty_flag = 1'b1;
        end else begin
          pos = (model_head + model_count - 1) % DQ_DEPTH;
          res.value = model_store[pos];
          if (op == OP_POP_BACK) model_count--;
        end
      end
      OP_SIZE:  res.value = WORD_W'(model_count);
      default:  res.value = (model_count == 0) ? WORD_W'(1) : WORD_W'(0);
    endcase
    return 1'b1;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic opcode_t rand_push_op();
    return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
  endfunction

  // Drive one command word; the prediction is made at the edge that accepts it.
  task automatic send_cmd(input opcode_t op, input logic [WORD_W-1:0] val);
    dq_result_t res;
    if (gaps_enabled) begin
      while ($urandom_range(0, 99) < 18) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start      <= 1'b1;
    opcode     <= op;
    push_value <= val;
    do @(posedge clk); while (busy);
    if (predict_deque(op, val, res)) pending_results.insert(pending_results.size(), res);
  endtask

  task automatic release_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Result checker: done is a one-cycle strobe, no back-pressure possible.
  always @(posedge clk) begin
    dq_result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word value=%h was_empty=%b",
                 $time, result_value, was_empty);
        error_count++;
      end else begin
        exp_res = pending_results[0];
        pending_results.delete(0);
        if (result_value !== exp_res.value) begin
          $display("%0t: result_value expected %h actual %h",
                   $time, exp_res.value, result_value);
          error_count++;
        end
        if (was_empty !== exp_res.empty_flag) begin
          $display("%0t: was_empty expected %b actual %b",
                   $time, exp_res.empty_flag, was_empty);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_access();
    send_cmd(OP_SIZE, 32'h0);
    send_cmd(OP_EMPTY, 32'hffff_ffff);
    send_cmd(OP_FRONT, 32'h0);
    send_cmd(OP_BACK, 32'h0);
    send_cmd(OP_POP_FRONT, 32'h1234_5678);
    send_cmd(OP_POP_BACK, 32'h0);
  endtask

  // extreme words at both ends; push front from head 0 wraps the index
  task automatic test_extremes_and_wrap();
    send_cmd(OP_PUSH_FRONT, 32'h8000_0000);
    send_cmd(OP_PUSH_BACK, 32'h7fff_ffff);
    send_cmd(OP_PUSH_FRONT, 32'hffff_ffff);
    send_cmd(OP_PUSH_BACK, 32'h0000_0000);
    send_cmd(OP_FRONT, 32'h0);
    send_cmd(OP_BACK, 32'h0);
    send_cmd(OP_SIZE, 32'h0);
    send_cmd(OP_EMPTY, 32'h0);
    send_cmd(OP_POP_FRONT, 32'h0);
    send_cmd(OP_POP_BACK, 32'h0);
    send_cmd(OP_POP_FRONT, 32'h0);
    send_cmd(OP_POP_BACK, 32'h0);
    send_cmd(OP_POP_FRONT, 32'h0);
    send_cmd(OP_EMPTY, 32'h0);
    send_cmd(OP_SIZE, 32'h0);
  endtask

  task automatic test_random_near_empty(input int n);
    repeat (n) send_cmd(opcode_t'($urandom_range(0, 7)), rand_word());
  endtask

  // mostly pushes until full, then extra pushes that must be dropped
  task automatic test_fill_and_overflow();
    gaps_enabled = 1'b0;
    while (model_count < DQ_DEPTH) begin
      if ($urandom_range(0, 99) < 92) send_cmd(rand_push_op(), rand_word());
      else send_cmd(opcode_t'($urandom_range(OP_FRONT, OP_EMPTY)), rand_word());
    end
    gaps_enabled = 1'b1;
    repeat (30) begin
      if ($urandom_range(0, 2) != 0) send_cmd(rand_push_op(), rand_word());
      else send_cmd(opcode_t'($urandom_range(OP_FRONT, OP_EMPTY)), rand_word());
    end
  endtask

  task automatic test_random_near_full(input int n);
    repeat (n) begin
      if ($urandom_range(0, 1)) send_cmd(rand_push_op(), rand_word());
      else send_cmd(opcode_t'($urandom_range(OP_FRONT, OP_POP_BACK)), rand_word());
    end
  endtask

  task automatic test_drain(input int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 85)
        send_cmd(opcode_t'($urandom_range(OP_POP_FRONT, OP_POP_BACK)), rand_word());
      else
        send_cmd(opcode_t'($urandom_range(0, 7)), rand_word());
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_empty_access();
    test_extremes_and_wrap();
    test_random_near_empty(300);
    test_fill_and_overflow();
    test_random_near_full(200);
    test_drain(250);
    release_start();
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("[double_ended_queue_core] OK");
    end else begin
      $display("[double_ended_queue_core] ERROR");
    end
    $finish;
  end

  initial begin
    #1600000;
    $display("[double_ended_queue_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/dq_pkg.sv
rtl/core/dq_ram.sv
rtl/core/double_ended_queue_core.sv
dv/double_ended_queue_core_tb.sv
